// ===== hdl/pcm_smooth_and_gain_core_assert.svh =====
// Assertion macros for the PCM smoothing and gain core.
`ifndef PCM_SMOOTH_AND_GAIN_CORE_ASSERT_SVH
`define PCM_SMOOTH_AND_GAIN_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PCM_SG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcm_smooth_and_gain_core: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PCM_SG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcm_smooth_and_gain_core: next-cycle check failed");

`endif

// ===== hdl/pcm_sg_pkg.sv =====
// Shared types and constants for the PCM smoothing and gain core.
package pcm_sg_pkg;

  localparam int unsigned SAMPLE_W           = 16;
  localparam int unsigned GAIN_W             = 16;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;

  localparam logic [GAIN_W-1:0]          GAIN_RESET = 16'd4096;
  localparam logic signed [SAMPLE_W-1:0] SAT_MAX    = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN    = 16'sh8000;

  // One pending result ahead of the gain stage, or one finished result.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } smp_t;

  // Buffer position: nothing held, first sample held, interior sample held.
  typedef enum logic [2:0] {
    PH_EMPTY = 3'b001,
    PH_FIRST = 3'b010,
    PH_MID   = 3'b100
  } phase_t;

endpackage

// ===== hdl/pcm_sg_gain.sv =====
// Gain stage: signed sample times unsigned fixed-point gain, round, saturate.
module pcm_sg_gain #(
  parameter int unsigned GAIN_FRAC_BITS = pcm_sg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic [pcm_sg_pkg::GAIN_W-1:0] gain,
  input  pcm_sg_pkg::smp_t              smp_i,
  output pcm_sg_pkg::smp_t              smp_o
);
  import pcm_sg_pkg::*;

  localparam int unsigned MAG_W  = SAMPLE_W + 1;
  localparam int unsigned PROD_W = MAG_W + GAIN_W;
  localparam int unsigned RND_W  = PROD_W + 1;
  localparam int unsigned R_W    = RND_W - GAIN_FRAC_BITS;

  localparam logic [RND_W-1:0] HALF_LSB = RND_W'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [R_W-1:0]   POS_LIM  = R_W'(32767);
  localparam logic [R_W-1:0]   NEG_LIM  = R_W'(32768);

  logic              neg;
  logic [MAG_W-1:0]  ext;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [RND_W-1:0]  rnd;
  logic [R_W-1:0]    r;

  always_comb begin
    neg  = smp_i.sample[SAMPLE_W-1];
    ext  = {smp_i.sample[SAMPLE_W-1], smp_i.sample};
    mag  = neg ? (MAG_W'(0) - ext) : ext;
    prod = PROD_W'(mag) * PROD_W'(gain);
    // round half away from zero: magnitude is rounded up at one half
    rnd  = {1'b0, prod} + HALF_LSB;
    r    = rnd[RND_W-1:GAIN_FRAC_BITS];

    smp_o.last = smp_i.last;
    if (neg) begin
      smp_o.sample = (r > NEG_LIM) ? SAT_MIN : (SAMPLE_W'(0) - r[SAMPLE_W-1:0]);
    end else begin
      smp_o.sample = (r > POS_LIM) ? SAT_MAX : r[SAMPLE_W-1:0];
    end
  end

endmodule

// ===== hdl/pcm_smooth_and_gain_core.sv =====
// PCM smoothing and gain core: 3-tap binomial smoother, saturating linear gain.
//
// Input words carry one signed 16-bit sample in in_tdata; in_tlast marks the
// last sample of a buffer. Interior samples are replaced by
// (prev + 2*cur + next) >>> 2; the first and last of a buffer pass as they are.
// Each result is scaled by cfg_wdata gain (unsigned, GAIN_FRAC_BITS fraction
// bits), rounded half away from zero and saturated to 16 bits.
// Results come out one sample behind: a word that ends a buffer releases two
// results (the held sample, then itself, with out_tlast set); a one-sample
// buffer gives one result.
// Pipeline: input word -> pending pair register (smoothing) -> output register
// (gain multiply). A result already computable at accept enters the pending pair
// register, then the output register. One word per cycle is taken while each
// word yields at most one result and out_tready stays high; a buffer end yielding
// two results holds in_tready low until the single gain multiplier drains the pair.
// out_tready low holds the output register; the pending pair fills and
// in_tready drops. Reset clears all pending results, the buffer position and
// sets the gain to unity (4096).
module pcm_smooth_and_gain_core #(
  parameter int unsigned GAIN_FRAC_BITS = pcm_sg_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [pcm_sg_pkg::GAIN_W-1:0]     cfg_wdata,   // gain_linear
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pcm_sg_pkg::SAMPLE_W-1:0]   in_tdata,    // [15:0] sample_in
  input  logic                              in_tlast,    // buffer_end
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pcm_sg_pkg::SAMPLE_W-1:0]   out_tdata,   // [15:0] sample_out
  output logic                              out_tlast    // last_out
);
  import pcm_sg_pkg::*;

  logic [GAIN_W-1:0]          gain_r, gain_nxt;
  phase_t                     phase_r, phase_nxt;
  logic signed [SAMPLE_W-1:0] held_r, held_nxt;
  logic signed [SAMPLE_W-1:0] older_r, older_nxt;
  logic [1:0]                 pend_v_r, pend_v_nxt;
  smp_t                       pend0_r, pend0_nxt;
  smp_t                       pend1_r, pend1_nxt;
  logic                       out_valid_r, out_valid_nxt;
  smp_t                       out_r, out_nxt;

  logic                       in_acc;
  logic                       pop;
  logic                       busy;
  logic [SAMPLE_W+1:0]        sum3;
  logic signed [SAMPLE_W-1:0] first_smp;
  smp_t                       head;
  smp_t                       gained;

  // phase decode
  always_comb begin
    busy      = 1'b0;
    first_smp = held_r;
    unique case (phase_r)
      PH_EMPTY: busy = 1'b0;
      PH_FIRST: begin
        busy      = 1'b1;
        first_smp = held_r;
      end
      PH_MID: begin
        busy      = 1'b1;
        first_smp = sum3[SAMPLE_W+1:2];
      end
      default: busy = 1'b0;
    endcase
  end

  assign sum3 = {{2{older_r[SAMPLE_W-1]}}, older_r}
              + {held_r[SAMPLE_W-1], held_r, 1'b0}
              + {{2{in_tdata[SAMPLE_W-1]}}, in_tdata};

  assign pop       = (pend_v_r != 2'b00) && (!out_valid_r || out_tready);
  assign in_tready = (pend_v_r == 2'b00) || (pop && (pend_v_r != 2'b11));
  assign in_acc    = in_tvalid && in_tready;
  assign head      = pend_v_r[0] ? pend0_r : pend1_r;

  pcm_sg_gain #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_gain (
    .gain  (gain_r),
    .smp_i (head),
    .smp_o (gained)
  );

  always_comb begin
    gain_nxt      = cfg_we ? cfg_wdata : gain_r;
    phase_nxt     = phase_r;
    held_nxt      = held_r;
    older_nxt     = older_r;
    pend_v_nxt    = pend_v_r;
    pend0_nxt     = pend0_r;
    pend1_nxt     = pend1_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    if (pop) begin
      if (pend_v_r[0]) begin
        pend_v_nxt[0] = 1'b0;
      end else begin
        pend_v_nxt[1] = 1'b0;
      end
      out_valid_nxt = 1'b1;
      out_nxt       = gained;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      pend_v_nxt       = {in_tlast, busy};
      pend0_nxt.sample = first_smp;
      pend0_nxt.last   = 1'b0;
      pend1_nxt.sample = in_tdata;
      pend1_nxt.last   = 1'b1;
      if (in_tlast) begin
        phase_nxt = PH_EMPTY;
      end else begin
        if (busy) begin
          older_nxt = held_r;
          phase_nxt = PH_MID;
        end else begin
          phase_nxt = PH_FIRST;
        end
        held_nxt = in_tdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      phase_r     <= PH_EMPTY;
      pend_v_r    <= 2'b00;
      out_valid_r <= 1'b0;
    end else begin
      gain_r      <= gain_nxt;
      phase_r     <= phase_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    older_r <= older_nxt;
    pend0_r <= pend0_nxt;
    pend1_r <= pend1_nxt;
    out_r   <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r.sample;
  assign out_tlast  = out_r.last;

`include "pcm_smooth_and_gain_core_assert.svh"

  // a buffer end with a sample held must queue both results
  `PCM_SG_ASSERT_NEXT(a_end_two_results, clk, rst_n, in_acc && in_tlast && busy, pend_v_r == 2'b11)
  // a buffer end always returns to the empty position
  `PCM_SG_ASSERT_NEXT(a_end_clears_phase, clk, rst_n, in_acc && in_tlast, phase_r == PH_EMPTY)
  // the held-sample result never carries the buffer end mark
  `PCM_SG_ASSERT_NOW(a_held_not_last, clk, rst_n, pend_v_r[0], !pend0_r.last)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the PCM smoothing and gain core.
`timescale 1ns / 100ps

module tb_top;
  import pcm_sg_pkg::*;

  localparam int ITEMS = 1550;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [GAIN_W-1:0]   cfg_wdata = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata = '0;    // [15:0] sample_in
  logic                in_tlast = 1'b0;  // buffer_end
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [SAMPLE_W-1:0] out_tdata;        // [15:0] sample_out
  logic                out_tlast;        // last_out

  int idle_pct = 23;
  int words_sent = 0;

  // Tracks the smoother/gain state and holds the results still owed by the core.
  class pcm_result_book;
    logic [GAIN_W-1:0]          gain;
    logic signed [SAMPLE_W-1:0] held;
    logic signed [SAMPLE_W-1:0] older;
    phase_t                     phase;
    smp_t                       owed[$];
    int                         errors;

    function new();
      gain = GAIN_RESET;
      held = '0;
      older = '0;
      phase = PH_EMPTY;
      errors = 0;
    endfunction

    // Q4.12 multiply, round half away from zero, saturate to 16 bits.
    function logic signed [SAMPLE_W-1:0] scaled(int s);
      longint mag;
      longint r;
      mag = (s < 0) ? -longint'(s) : longint'(s);
      r = (mag * longint'(gain) + (longint'(1) << (GAIN_FRAC_BITS_DEF - 1)))
          >> GAIN_FRAC_BITS_DEF;
      if (s < 0) return (r > 32768) ? SAT_MIN : 16'(-r);
      return (r > 32767) ? SAT_MAX : 16'(r);
    endfunction

    function void owe(logic signed [SAMPLE_W-1:0] s, logic last);
      smp_t e;
      e.sample = s;
      e.last = last;
      owed.push_back(e);
    endfunction

    function void note_word(logic signed [SAMPLE_W-1:0] x, logic buf_end);
      case (phase)
        PH_FIRST: owe(scaled(int'(held)), 1'b0);
        PH_MID:   owe(scaled((int'(older) + 2 * int'(held) + int'(x)) >>> 2), 1'b0);
        default: ;
      endcase
      if (buf_end) begin
        owe(scaled(int'(x)), 1'b1);
        phase = PH_EMPTY;
      end else begin
        if (phase == PH_FIRST || phase == PH_MID) begin
          older = held;
          phase = PH_MID;
        end else begin
          phase = PH_FIRST;
        end
        held = x;
      end
    endfunction

    function void check_word(logic [SAMPLE_W-1:0] data, logic last);
      smp_t e;
      if (owed.size() == 0) begin
        $error("result word with none owed: sample_out %0d last_out %0d",
               $signed(data), last);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (data !== e.sample) begin
        $error("sample_out: expected %0d, got %0d", e.sample, $signed(data));
        errors++;
      end
      if (last !== e.last) begin
        $error("last_out: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  pcm_result_book book = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pcm_smooth_and_gain_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_word(out_tdata, out_tlast);
  end

  task automatic send_word(input logic [SAMPLE_W-1:0] s, input logic buf_end);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 16'($urandom);
      in_tlast  <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= buf_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    book.note_word(s, buf_end);
    words_sent++;
  endtask

  // Let the core drain completely, then load a new gain.
  task automatic retune(input logic [GAIN_W-1:0] g);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.owed.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.gain = g;
  endtask

  initial begin
    int buf_len;
    int phase_no;
    int phase_words;
    logic [GAIN_W-1:0] g;
    logic [SAMPLE_W-1:0] s;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unity gain from reset: two one-word buffers, then two-, four- and three-word buffers
    send_word(16'h7FFF, 1'b1);
    send_word(16'h8000, 1'b1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h8000, 1'b0);
    send_word(16'h7FFF, 1'b1);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h7FFF, 1'b1);
    // negative sums must floor
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFE, 1'b0);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFD, 1'b1);
    // saturation at full gain
    retune(16'hFFFF);
    send_word(16'h7FFF, 1'b1);
    send_word(16'h8000, 1'b1);
    send_word(16'h0008, 1'b1);
    retune(16'h0000);
    send_word(16'h1234, 1'b0);
    send_word(16'h8000, 1'b1);
    // half gain: exact halves round away from zero
    retune(16'd2048);
    send_word(16'h0001, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0003, 1'b0);
    send_word(16'hFFFD, 1'b1);
    // gain change while a buffer is open
    retune(GAIN_RESET);
    send_word(16'd100, 1'b0);
    send_word(16'd200, 1'b0);
    retune(16'd8192);
    send_word(16'd300, 1'b0);
    send_word(16'd400, 1'b1);

    phase_no = 0;
    while (words_sent < ITEMS) begin
      idle_pct = (phase_no == 2) ? 0 : 23;
      case ($urandom_range(7))
        0: g = '0;
        1: g = '1;
        2: g = 16'd1;
        3: g = GAIN_RESET;
        4: g = 16'($urandom_range(3000, 9000));
        default: g = 16'($urandom);
      endcase
      retune(g);
      phase_words = 0;
      while (phase_words < 160 && words_sent < ITEMS) begin
        buf_len = ($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        for (int k = 1; k <= buf_len; k++) begin
          case ($urandom_range(9))
            0: s = 16'h7FFF;
            1: s = 16'h8000;
            2, 3: s = 16'($signed($urandom_range(128)) - 64);
            4: s = 16'($urandom_range(3000)) ^ {16{1'($urandom)}};
            default: s = 16'($urandom);
          endcase
          send_word(s, k == buf_len);
        end
        phase_words += buf_len;
      end
      phase_no++;
    end
    idle_pct = 23;

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (book.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (book.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
